@@ rtl/utf8_validate_count_unit_assert.svh @@
// Assertion macros for the UTF-8 validate and count unit.
// Each macro takes a label, the clock, the active-low reset, a trigger
// condition and the expected consequence.
`ifndef UTF8_VALIDATE_COUNT_UNIT_ASSERT_SVH
`define UTF8_VALIDATE_COUNT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Consequence holds in the same cycle as the trigger.
`define UVC_ASSERT_SAME(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("uvc assertion failed");

// Consequence holds in the cycle after the trigger.
`define UVC_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("uvc assertion failed");

`else

`define UVC_ASSERT_SAME(label, clk, rst_n, trig, cons)
`define UVC_ASSERT_NEXT(label, clk, rst_n, trig, cons)

`endif

`endif

@@ rtl/uvc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package uvc_pkg;

    // Width of the running totals and of the reported counts
    localparam int COUNT_WIDTH = 32;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [7:0]             byte_t;
    typedef logic [2:0]             seq_width_t;
    typedef logic [1:0]             held_t;
    // Amount added to a total in one step (at most four)
    typedef logic [2:0]             incr_t;

    localparam count_t COUNT_MAX = '1;

    // Lead byte classes
    localparam byte_t ASCII_LIMIT   = 8'h80;
    localparam byte_t LEAD_MIN      = 8'hC2;
    localparam byte_t LEAD_MAX      = 8'hF4;
    localparam byte_t LEAD3_MIN     = 8'hE0;
    localparam byte_t LEAD4_MIN     = 8'hF0;

    // Leads that narrow the second byte
    localparam byte_t LEAD_E0       = 8'hE0;
    localparam byte_t LEAD_ED       = 8'hED;
    localparam byte_t LEAD_F0       = 8'hF0;
    localparam byte_t LEAD_F4       = 8'hF4;

    // Continuation byte bounds
    localparam byte_t CONT_LOW      = 8'h80;
    localparam byte_t CONT_HIGH     = 8'hBF;
    localparam byte_t CONT_LOW_E0   = 8'hA0;
    localparam byte_t CONT_HIGH_ED  = 8'h9F;
    localparam byte_t CONT_LOW_F0   = 8'h90;
    localparam byte_t CONT_HIGH_F4  = 8'h8F;

    localparam seq_width_t SEQ_NONE = 3'd0;
    localparam seq_width_t SEQ_TWO  = 3'd2;
    localparam seq_width_t SEQ_THREE = 3'd3;
    localparam seq_width_t SEQ_FOUR = 3'd4;

    // Saturating add of a small increment
    function automatic count_t sat_add(input count_t x, input incr_t n);
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, x} + {{(COUNT_WIDTH - 2){1'b0}}, n};
        if (sum[COUNT_WIDTH])
        begin
            return COUNT_MAX;
        end
        return sum[COUNT_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/uvc_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Byte channel: one string byte per beat
interface uvc_byte_if;
    import uvc_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel: one beat per string
interface uvc_result_if;
    import uvc_pkg::*;

    logic   valid;
    logic   ready;
    count_t code_point_count;
    count_t ill_formed_count;
    logic   all_well_formed;

    modport source (output valid, output code_point_count, output ill_formed_count,
                    output all_well_formed, input ready);
    modport sink   (input valid, input code_point_count, input ill_formed_count,
                    input all_well_formed, output ready);
endinterface

`default_nettype wire

@@ rtl/utf8_validate_count_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Result path: once accepted, the last byte passes the input register, then the
// result register, before its result beat is valid.
// Throughput: 1 byte per cycle; the input stage stalls only while a last byte
// waits behind a result beat that has not been taken.
// Reset: rst_n asynchronous, active low; clears the pending sequence, both
// totals and all valid flags. No clearing pass.
module utf8_validate_count_unit
    import uvc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    uvc_byte_if.sink    byte_in,
    uvc_result_if.source result_out
);

    // Input register
    logic       s1_valid_reg, s1_valid_next;
    byte_t      s1_byte_reg;
    logic       s1_last_reg;

    // Decoder state
    byte_t      held_lead_reg, held_lead_next;
    seq_width_t seq_width_reg, seq_width_next;
    held_t      bytes_held_reg, bytes_held_next;
    count_t     step_total_reg, step_total_next;
    count_t     bad_total_reg, bad_total_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    count_t     out_steps_reg, out_steps_next;
    count_t     out_bad_reg, out_bad_next;
    logic       out_good_reg, out_good_next;

    logic       s1_go;
    logic       in_fire;
    logic       s1_done_last;

    // Per-byte decode signals
    logic       pending;
    byte_t      cont_low;
    byte_t      cont_high;
    logic       fits;
    held_t      held_inc;
    logic       complete;
    logic       lead_ascii;
    logic       lead_bad;
    seq_width_t lead_width;
    incr_t      flush_amt;
    incr_t      step_amt;
    incr_t      bad_amt;
    byte_t      lead_after;
    seq_width_t width_after;
    held_t      held_after;
    count_t     step_sum;
    count_t     bad_sum;

    // Handshake: stage 1 drains unless a last byte meets a full result register that is not taken
    assign s1_go        = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result_out.ready);
    assign byte_in.ready = !s1_valid_reg || s1_go;
    assign in_fire      = byte_in.valid && byte_in.ready;
    assign s1_done_last = s1_go && s1_last_reg;

    assign s1_valid_next = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    // Allowed range for the next continuation byte
    always_comb
    begin
        cont_low  = CONT_LOW;
        cont_high = CONT_HIGH;
        if (bytes_held_reg == 2'd1)
        begin
            priority if (held_lead_reg == LEAD_E0)
            begin
                cont_low = CONT_LOW_E0;
            end
            else if (held_lead_reg == LEAD_ED)
            begin
                cont_high = CONT_HIGH_ED;
            end
            else if (held_lead_reg == LEAD_F0)
            begin
                cont_low = CONT_LOW_F0;
            end
            else if (held_lead_reg == LEAD_F4)
            begin
                cont_high = CONT_HIGH_F4;
            end
            else
            begin
                // other leads keep the full continuation range
            end
        end
    end

    assign pending  = seq_width_reg != SEQ_NONE;
    assign fits     = pending && (s1_byte_reg >= cont_low) && (s1_byte_reg <= cont_high);
    assign held_inc = bytes_held_reg + 2'd1;
    assign complete = (held_inc == 2'd0) || ({1'b0, held_inc} >= seq_width_reg);

    // Lead byte classification
    assign lead_ascii = s1_byte_reg < ASCII_LIMIT;
    assign lead_bad   = !lead_ascii && ((s1_byte_reg < LEAD_MIN) || (s1_byte_reg > LEAD_MAX));
    always_comb
    begin
        priority if (s1_byte_reg < LEAD3_MIN)
        begin
            lead_width = SEQ_TWO;
        end
        else if (s1_byte_reg < LEAD4_MIN)
        begin
            lead_width = SEQ_THREE;
        end
        else
        begin
            lead_width = SEQ_FOUR;
        end
    end

    // One byte step: extend, complete, or break and re-examine as a lead
    always_comb
    begin
        step_amt    = '0;
        bad_amt     = '0;
        flush_amt   = '0;
        lead_after  = held_lead_reg;
        width_after = seq_width_reg;
        held_after  = bytes_held_reg;

        if (fits)
        begin
            if (complete)
            begin
                step_amt    = 3'd1;
                lead_after  = '0;
                width_after = SEQ_NONE;
                held_after  = '0;
            end
            else
            begin
                held_after = held_inc;
            end
        end
        else
        begin
            flush_amt = pending ? {1'b0, bytes_held_reg} : 3'd0;
            lead_after  = '0;
            width_after = SEQ_NONE;
            held_after  = '0;
            priority if (lead_ascii)
            begin
                step_amt = flush_amt + 3'd1;
                bad_amt  = flush_amt;
            end
            else if (lead_bad)
            begin
                step_amt = flush_amt + 3'd1;
                bad_amt  = flush_amt + 3'd1;
            end
            else
            begin
                step_amt    = flush_amt;
                bad_amt     = flush_amt;
                lead_after  = s1_byte_reg;
                width_after = lead_width;
                held_after  = 2'd1;
            end
        end

        // A sequence cut short by the end of the string counts byte by byte
        if (s1_last_reg && (width_after != SEQ_NONE))
        begin
            step_amt = step_amt + {1'b0, held_after};
            bad_amt  = bad_amt + {1'b0, held_after};
        end
    end

    assign step_sum = sat_add(step_total_reg, step_amt);
    assign bad_sum  = sat_add(bad_total_reg, bad_amt);

    // Next state and result register
    always_comb
    begin
        held_lead_next  = held_lead_reg;
        seq_width_next  = seq_width_reg;
        bytes_held_next = bytes_held_reg;
        step_total_next = step_total_reg;
        bad_total_next  = bad_total_reg;
        out_steps_next  = out_steps_reg;
        out_bad_next    = out_bad_reg;
        out_good_next   = out_good_reg;
        out_valid_next  = result_out.ready ? 1'b0 : out_valid_reg;

        if (s1_go)
        begin
            if (s1_last_reg)
            begin
                held_lead_next  = '0;
                seq_width_next  = SEQ_NONE;
                bytes_held_next = '0;
                step_total_next = '0;
                bad_total_next  = '0;
                out_valid_next  = 1'b1;
                out_steps_next  = step_sum;
                out_bad_next    = bad_sum;
                out_good_next   = bad_sum == '0;
            end
            else
            begin
                held_lead_next  = lead_after;
                seq_width_next  = width_after;
                bytes_held_next = held_after;
                step_total_next = step_sum;
                bad_total_next  = bad_sum;
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            held_lead_reg  <= '0;
            seq_width_reg  <= SEQ_NONE;
            bytes_held_reg <= '0;
            step_total_reg <= '0;
            bad_total_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            held_lead_reg  <= held_lead_next;
            seq_width_reg  <= seq_width_next;
            bytes_held_reg <= bytes_held_next;
            step_total_reg <= step_total_next;
            bad_total_reg  <= bad_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= byte_in.data_byte;
            s1_last_reg <= byte_in.last_byte;
        end
        out_steps_reg <= out_steps_next;
        out_bad_reg   <= out_bad_next;
        out_good_reg  <= out_good_next;
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.code_point_count = out_steps_reg;
    assign result_out.ill_formed_count = out_bad_reg;
    assign result_out.all_well_formed  = out_good_reg;

    // Checks
`include "utf8_validate_count_unit_assert.svh"

    `UVC_ASSERT_SAME(a_held_below_width, clk, rst_n, seq_width_reg != SEQ_NONE, ({1'b0, bytes_held_reg} < seq_width_reg) && (bytes_held_reg != 2'd0) && (seq_width_reg >= SEQ_TWO) && (seq_width_reg <= SEQ_FOUR))
    `UVC_ASSERT_NEXT(a_last_clears, clk, rst_n, s1_done_last, out_valid_reg && (seq_width_reg == SEQ_NONE) && (step_total_reg == '0) && (bad_total_reg == '0))
    `UVC_ASSERT_SAME(a_steps_cover_bad, clk, rst_n, out_valid_reg, out_steps_reg >= out_bad_reg)
    `UVC_ASSERT_SAME(a_good_flag, clk, rst_n, out_valid_reg, out_good_reg == (out_bad_reg == '0))
    `UVC_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_reg && !result_out.ready, out_valid_reg && $stable(out_steps_reg) && $stable(out_bad_reg))

endmodule

`default_nettype wire
